### rtl/core/rqp_pkg.sv
package rqp_pkg;

  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } pix_t;

  typedef struct packed {
    logic vld;
    logic full;
  } ctl_t;

  localparam int unsigned CODE_W = 10;
  localparam int unsigned PAD_W  = 6;
  localparam int unsigned PROD_W = 26;

  localparam logic [15:0] COEF_YR = 16'd13933;
  localparam logic [15:0] COEF_YG = 16'd46871;
  localparam logic [15:0] COEF_YB = 16'd4732;
  localparam logic [15:0] ROUND_HALF = 16'd32768;

  localparam logic [15:0] SU_FULL = 16'd35318;
  localparam logic [15:0] SV_FULL = 16'd41615;
  localparam logic [15:0] SU_LIM  = 16'd36124;
  localparam logic [15:0] SV_LIM  = 16'd42566;

  localparam logic [9:0] CODE_MIN = 10'd0;
  localparam logic [9:0] CODE_MAX = 10'd1023;
  localparam logic [9:0] LIM_LO   = 10'd64;
  localparam logic [9:0] LIM_HI   = 10'd940;
  localparam logic [9:0] LIM_CHI  = 10'd960;
  localparam logic [9:0] UV_MID   = 10'd512;

  function automatic logic [9:0] luma_raw(pix_t p);
    logic [PROD_W-1:0] acc;
    acc = PROD_W'(COEF_YR) * PROD_W'(p.r)
        + PROD_W'(COEF_YG) * PROD_W'(p.g)
        + PROD_W'(COEF_YB) * PROD_W'(p.b)
        + PROD_W'(ROUND_HALF);
    return acc[PROD_W-1:16];
  endfunction

  function automatic logic [9:0] clamp_code(logic [9:0] x, logic full);
    logic [9:0] lo;
    logic [9:0] hi;
    lo = full ? CODE_MIN : LIM_LO;
    hi = full ? CODE_MAX : LIM_HI;
    if (x < lo) begin
      return lo;
    end else if (x > hi) begin
      return hi;
    end else begin
      return x;
    end
  endfunction

endpackage

### rtl/core/rqp_prep.sv
module rqp_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [3:0][15:0]        red_i,
  input  logic [3:0][15:0]        green_i,
  input  logic [3:0][15:0]        blue_i,
  input  rqp_pkg::ctl_t           ctl_i,
  output rqp_pkg::pix_t [3:0]     pix_o,
  output rqp_pkg::ctl_t           ctl_o
);
  import rqp_pkg::*;

  pix_t [3:0] pix_nxt;
  pix_t [3:0] pix_r;
  ctl_t       ctl_r;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      pix_nxt[p].r = clamp_code(red_i[p][15:PAD_W], ctl_i.full);
      pix_nxt[p].g = clamp_code(green_i[p][15:PAD_W], ctl_i.full);
      pix_nxt[p].b = clamp_code(blue_i[p][15:PAD_W], ctl_i.full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign pix_o = pix_r;
  assign ctl_o = ctl_r;

endmodule

### rtl/core/rqp_luma.sv
module rqp_luma (
  input  logic                clk,
  input  logic                rst_n,
  input  rqp_pkg::pix_t [3:0] pix_i,
  input  rqp_pkg::ctl_t       ctl_i,
  output logic [3:0][9:0]     y_o
);
  import rqp_pkg::*;

  logic [3:0][9:0] raw_nxt;
  logic [3:0][9:0] raw_r;
  logic [3:0][9:0] y3_nxt;
  logic [3:0][9:0] y3_r;
  logic [3:0][9:0] y4_r;
  logic [3:0][9:0] y5_r;
  logic            full2_r;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      raw_nxt[p] = luma_raw(pix_i[p]);
      y3_nxt[p]  = clamp_code(raw_r[p], full2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full2_r <= 1'b0;
    end else begin
      full2_r <= ctl_i.full;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
    y3_r  <= y3_nxt;
    y4_r  <= y3_r;
    y5_r  <= y4_r;
  end

  assign y_o = y5_r;

endmodule

### rtl/core/rqp_chroma.sv
module rqp_chroma (
  input  logic                clk,
  input  logic                rst_n,
  input  rqp_pkg::pix_t [3:0] pix_i,
  input  rqp_pkg::ctl_t       ctl_i,
  output logic [9:0]          u_o,
  output logic [9:0]          v_o,
  output rqp_pkg::ctl_t       ctl_o
);
  import rqp_pkg::*;

  ctl_t ctl2_r;
  ctl_t ctl3_r;
  ctl_t ctl4_r;
  ctl_t ctl5_r;

  logic [11:0] sum_r_nxt;
  logic [11:0] sum_g_nxt;
  logic [11:0] sum_b_nxt;
  pix_t        avg_nxt;
  pix_t        avg_r;

  logic [9:0]         yc_nxt;
  logic signed [10:0] du_nxt;
  logic signed [10:0] dv_nxt;
  logic signed [10:0] du_r;
  logic signed [10:0] dv_r;

  logic [9:0]        mag_u;
  logic [9:0]        mag_v;
  logic [15:0]       su;
  logic [15:0]       sv;
  logic [PROD_W-1:0] prod_u;
  logic [PROD_W-1:0] prod_v;
  logic [9:0]        qu_r;
  logic [9:0]        qv_r;
  logic              nu_r;
  logic              nv_r;

  logic signed [11:0] u_nxt;
  logic signed [11:0] v_nxt;
  logic signed [11:0] lo_s;
  logic signed [11:0] hi_s;
  logic [9:0]         u_code_nxt;
  logic [9:0]         v_code_nxt;
  logic [9:0]         u_r;
  logic [9:0]         v_r;

  always_comb begin
    sum_r_nxt = 12'(pix_i[0].r) + 12'(pix_i[1].r) + 12'(pix_i[2].r) + 12'(pix_i[3].r) + 12'd2;
    sum_g_nxt = 12'(pix_i[0].g) + 12'(pix_i[1].g) + 12'(pix_i[2].g) + 12'(pix_i[3].g) + 12'd2;
    sum_b_nxt = 12'(pix_i[0].b) + 12'(pix_i[1].b) + 12'(pix_i[2].b) + 12'(pix_i[3].b) + 12'd2;
    avg_nxt.r = sum_r_nxt[11:2];
    avg_nxt.g = sum_g_nxt[11:2];
    avg_nxt.b = sum_b_nxt[11:2];
  end

  always_comb begin
    yc_nxt = luma_raw(avg_r);
    du_nxt = $signed({1'b0, avg_r.b}) - $signed({1'b0, yc_nxt});
    dv_nxt = $signed({1'b0, avg_r.r}) - $signed({1'b0, yc_nxt});
  end

  always_comb begin
    mag_u  = du_r[10] ? 10'(-du_r) : du_r[9:0];
    mag_v  = dv_r[10] ? 10'(-dv_r) : dv_r[9:0];
    su     = ctl3_r.full ? SU_FULL : SU_LIM;
    sv     = ctl3_r.full ? SV_FULL : SV_LIM;
    prod_u = PROD_W'(mag_u) * PROD_W'(su) + PROD_W'(ROUND_HALF);
    prod_v = PROD_W'(mag_v) * PROD_W'(sv) + PROD_W'(ROUND_HALF);
  end

  always_comb begin
    u_nxt = $signed(12'(UV_MID)) + (nu_r ? -$signed({2'b00, qu_r}) : $signed({2'b00, qu_r}));
    v_nxt = $signed(12'(UV_MID)) + (nv_r ? -$signed({2'b00, qv_r}) : $signed({2'b00, qv_r}));
    lo_s  = ctl4_r.full ? $signed(12'(CODE_MIN)) : $signed(12'(LIM_LO));
    hi_s  = ctl4_r.full ? $signed(12'(CODE_MAX)) : $signed(12'(LIM_CHI));
    if (u_nxt < lo_s) begin
      u_code_nxt = lo_s[9:0];
    end else if (u_nxt > hi_s) begin
      u_code_nxt = hi_s[9:0];
    end else begin
      u_code_nxt = u_nxt[9:0];
    end
    if (v_nxt < lo_s) begin
      v_code_nxt = lo_s[9:0];
    end else if (v_nxt > hi_s) begin
      v_code_nxt = hi_s[9:0];
    end else begin
      v_code_nxt = v_nxt[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      ctl2_r <= ctl_i;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    avg_r <= avg_nxt;
    du_r  <= du_nxt;
    dv_r  <= dv_nxt;
    qu_r  <= prod_u[PROD_W-1:16];
    qv_r  <= prod_v[PROD_W-1:16];
    nu_r  <= du_r[10];
    nv_r  <= dv_r[10];
    u_r   <= u_code_nxt;
    v_r   <= v_code_nxt;
  end

  assign u_o   = u_r;
  assign v_o   = v_r;
  assign ctl_o = ctl5_r;

endmodule

### rtl/core/rgb_quad_to_p010_yuv420.sv
// Channel  Handshake                Word
// input    start (busy held low)    in_* twelve 16-bit RGB components of a 2x2 quad
// result   out_valid strobe         out_* four luma words, one U and one V word
// config   cfg_valid / cfg_ready    cfg_full_range
//
// A quad is accepted in every cycle; its result word passes through five register stages:
// clamp, luma and average, average luma, chroma scaling, chroma clamp.
// Reset is synchronous and active low; it clears the valid bits and selects limited range.
// The receiver cannot stall, so the pipeline never stops and busy stays low.
module rgb_quad_to_p010_yuv420 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_top_left_red,
  input  logic [15:0] in_top_left_green,
  input  logic [15:0] in_top_left_blue,
  input  logic [15:0] in_top_right_red,
  input  logic [15:0] in_top_right_green,
  input  logic [15:0] in_top_right_blue,
  input  logic [15:0] in_bottom_left_red,
  input  logic [15:0] in_bottom_left_green,
  input  logic [15:0] in_bottom_left_blue,
  input  logic [15:0] in_bottom_right_red,
  input  logic [15:0] in_bottom_right_green,
  input  logic [15:0] in_bottom_right_blue,
  output logic        out_valid,
  output logic [15:0] out_luma_top_left,
  output logic [15:0] out_luma_top_right,
  output logic [15:0] out_luma_bottom_left,
  output logic [15:0] out_luma_bottom_right,
  output logic [15:0] out_chroma_u,
  output logic [15:0] out_chroma_v,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_full_range
);
  import rqp_pkg::*;

  logic            full_range_r;
  logic [3:0][15:0] red;
  logic [3:0][15:0] green;
  logic [3:0][15:0] blue;
  ctl_t            ctl_in;
  ctl_t            ctl1;
  ctl_t            ctl_out;
  pix_t [3:0]      pix1;
  logic [3:0][9:0] y_code;
  logic [9:0]      u_code;
  logic [9:0]      v_code;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_range_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      full_range_r <= cfg_full_range;
    end
  end

  assign red   = {in_bottom_right_red, in_bottom_left_red,
                  in_top_right_red, in_top_left_red};
  assign green = {in_bottom_right_green, in_bottom_left_green,
                  in_top_right_green, in_top_left_green};
  assign blue  = {in_bottom_right_blue, in_bottom_left_blue,
                  in_top_right_blue, in_top_left_blue};

  assign ctl_in.vld  = start && !busy;
  assign ctl_in.full = full_range_r;

  rqp_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .red_i   (red),
    .green_i (green),
    .blue_i  (blue),
    .ctl_i   (ctl_in),
    .pix_o   (pix1),
    .ctl_o   (ctl1)
  );

  rqp_luma u_luma (
    .clk   (clk),
    .rst_n (rst_n),
    .pix_i (pix1),
    .ctl_i (ctl1),
    .y_o   (y_code)
  );

  rqp_chroma u_chroma (
    .clk   (clk),
    .rst_n (rst_n),
    .pix_i (pix1),
    .ctl_i (ctl1),
    .u_o   (u_code),
    .v_o   (v_code),
    .ctl_o (ctl_out)
  );

  assign out_valid             = ctl_out.vld;
  assign out_luma_top_left     = {y_code[0], PAD_W'(0)};
  assign out_luma_top_right    = {y_code[1], PAD_W'(0)};
  assign out_luma_bottom_left  = {y_code[2], PAD_W'(0)};
  assign out_luma_bottom_right = {y_code[3], PAD_W'(0)};
  assign out_chroma_u          = {u_code, PAD_W'(0)};
  assign out_chroma_v          = {v_code, PAD_W'(0)};

endmodule
